>>> src/bfnc_pkg.sv
// ----------------------------------------------------------------------------
// bfnc_pkg
// Types and constants shared by the negative cycle detector.
// ----------------------------------------------------------------------------
package bfnc_pkg;

   localparam int MAX_VERTICES_DEF = 256;
   localparam int MAX_EDGES_DEF    = 1024;
   localparam int WEIGHT_BITS      = 16;
   localparam int VERT_BITS        = 8;
   localparam int DIST_BITS        = 48;

   typedef struct packed {
      logic [VERT_BITS-1:0]          src;
      logic [VERT_BITS-1:0]          dst;
      logic signed [WEIGHT_BITS-1:0] weight;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic negative_cycle;
      logic overflow;
   } rsp_type;

   // one queued edge between front and back
   typedef struct packed {
      req_type item;
   } cmd_type;

endpackage

>>> src/bfnc_ram.sv
// ----------------------------------------------------------------------------
// bfnc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/bfnc_front.sv
// ----------------------------------------------------------------------------
// bfnc_front
// Accepts edge transactions and places them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module bfnc_front import bfnc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_take,
   output cmd_type q_data
);

   cmd_type     buf_ff [2];
   cmd_type     buf_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        acc;

   assign full    = (cnt_ff == 2'd2);
   assign acc     = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data  = buf_ff[0];

   // shift queue
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (q_take && q_valid) begin
         buf_in[0] = buf_ff[1];
         cnt_in    = cnt_in - 2'd1;
      end
      if (acc) begin
         buf_in[cnt_in[0]] = '{item: req_data};
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
      buf_ff <= buf_in;
   end

endmodule

>>> src/bfnc_back.sv
// ----------------------------------------------------------------------------
// bfnc_back
// Stores edges and runs the relaxation passes and the check pass.
// ----------------------------------------------------------------------------
module bfnc_back import bfnc_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [VERT_BITS-1:0] top_vertex,
   input  logic                 q_valid,
   output logic                 q_take,
   input  cmd_type              q_data,
   output logic                 empty,
   input  logic                 pop,
   output rsp_type              rsp_data
);

   localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int VA = $clog2(MAX_VERTICES);
   localparam int CB = $clog2(MAX_EDGES + 1);
   localparam int EW = 2 * VERT_BITS + WEIGHT_BITS;

   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001,
      S_INIT  = 7'b0000010,
      S_RDE   = 7'b0000100,
      S_RDD   = 7'b0001000,
      S_CMP   = 7'b0010000,
      S_NEXT  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type          st_ff, st_in;
   logic [CB-1:0]      cnt_ff, cnt_in;
   logic [CB-1:0]      k_ff, k_in;
   logic [8:0]         pass_ff, pass_in;
   logic               ovf_ff, ovf_in;
   logic               neg_ff, neg_in;
   logic               rsp_v_ff, rsp_v_in;
   rsp_type            rsp_ff, rsp_in;
   logic [MAX_VERTICES-1:0] rch_ff, rch_in;
   logic [VA-1:0]      clr_ff, clr_in;
   logic [DIST_BITS-1:0] sum_ff, sum_in;

   // edge store
   logic          e_we;
   logic [EA-1:0] e_wa, e_ra;
   logic [EW-1:0] e_wd, e_rd;
   logic [VERT_BITS-1:0] e_src, e_dst;
   logic signed [WEIGHT_BITS-1:0] e_w;

   // distance store, read twice through two copies
   logic                 d_we;
   logic [VA-1:0]        d_wa, d_ra0, d_ra1;
   logic [DIST_BITS-1:0] d_wd, d_rd0, d_rd1;

   assign {e_src, e_dst, e_w} = e_rd;

   bfnc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
      .clock, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   bfnc_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist0 (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra0), .rd_data(d_rd0));
   bfnc_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist1 (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra1), .rd_data(d_rd1));

   logic src_ok, dst_ok, use_e, relax;
   logic [VA-1:0] sv, dv;

   assign sv = VA'(e_src);
   assign dv = VA'(e_dst);
   assign src_ok = (e_src <= top_vertex) && (32'(e_src) < MAX_VERTICES);
   assign dst_ok = (e_dst <= top_vertex) && (32'(e_dst) < MAX_VERTICES);
   assign use_e  = src_ok && dst_ok && rch_ff[sv];
   assign relax  = !rch_ff[dv] || ($signed(sum_ff) < $signed(d_rd1));

   assign empty    = !rsp_v_ff;
   assign rsp_data = rsp_ff;

   // run sequencer
   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; k_in = k_ff; pass_in = pass_ff;
      ovf_in = ovf_ff; neg_in = neg_ff; rch_in = rch_ff; clr_in = clr_ff;
      rsp_v_in = rsp_v_ff; rsp_in = rsp_ff; sum_in = sum_ff;
      q_take = 1'b0;
      e_we = 1'b0; e_wa = EA'(cnt_ff); e_wd = {q_data.item.src, q_data.item.dst,
         q_data.item.weight};
      e_ra = EA'(k_ff);
      d_we = 1'b0; d_wa = dv; d_wd = sum_ff;
      d_ra0 = sv; d_ra1 = dv;
      if (pop && rsp_v_ff) rsp_v_in = 1'b0;
      unique case (st_ff)
         S_LOAD: begin
            if (q_valid) begin
               q_take = 1'b1;
               if (32'(cnt_ff) < MAX_EDGES) begin
                  e_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else ovf_in = 1'b1;
               if (q_data.item.last) begin
                  rch_in = '0;
                  if (32'(top_vertex) < MAX_VERTICES)
                     rch_in[VA'(top_vertex)] = 1'b1;
                  pass_in = '0; k_in = '0; neg_in = 1'b0;
                  clr_in = VA'(top_vertex);
                  st_in = S_INIT;
               end
            end
         end
         // zero the source distance
         S_INIT: begin
            d_we = 1'b1; d_wa = clr_ff; d_wd = '0;
            st_in = (k_ff < cnt_ff) ? S_RDE : S_NEXT;
         end
         S_RDE: st_in = S_RDD;
         S_RDD: begin
            sum_in = d_rd0 + DIST_BITS'(e_w);
            st_in = S_CMP;
         end
         S_CMP: begin
            if (use_e && relax) begin
               if (pass_ff == 9'(top_vertex)) neg_in = 1'b1;
               else begin
                  d_we = 1'b1;
                  rch_in[dv] = 1'b1;
               end
            end
            k_in = k_ff + 1'b1;
            e_ra = EA'(k_in);
            st_in = (k_in < cnt_ff) ? S_RDE : S_NEXT;
         end
         S_NEXT: begin
            k_in = '0;
            e_ra = '0;
            if (pass_ff == 9'(top_vertex) || cnt_ff == '0) st_in = S_OUT;
            else begin
               pass_in = pass_ff + 1'b1;
               st_in = S_RDE;
            end
         end
         S_OUT: begin
            if (!rsp_v_ff || pop) begin
               rsp_v_in = 1'b1;
               rsp_in = '{negative_cycle: neg_ff, overflow: ovf_ff};
               cnt_in = '0; ovf_in = 1'b0;
               st_in = S_LOAD;
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; cnt_ff <= '0; ovf_ff <= 1'b0; rsp_v_ff <= 1'b0;
         pass_ff <= '0; k_ff <= '0; neg_ff <= 1'b0; rch_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in; rsp_v_ff <= rsp_v_in;
         pass_ff <= pass_in; k_ff <= k_in; neg_ff <= neg_in; rch_ff <= rch_in;
      end
      rsp_ff <= rsp_in; clr_ff <= clr_in; sum_ff <= sum_in;
   end

endmodule

>>> src/bellman_ford_negative_cycle_top.sv
// ----------------------------------------------------------------------------
// bellman_ford_negative_cycle_top
// Negative cycle detector over a stored edge list.
// ----------------------------------------------------------------------------
// channel | ports                  | handshake
// edge    | req_data, push, full   | push && !full
// verdict | rsp_data, empty, pop   | pop && !empty
// csr     | csr_we, csr_wdata      | csr_we
// an edge without last is only stored, the back end stays in S_LOAD;
// a run is a series of relaxation passes over the stored edges and a check pass:
// each edge needs an edge read, a distance read and a compare with write back,
// plus S_INIT once, S_NEXT after each pass and S_OUT for the result;
// reset clears counters, the queue and the reached flags; no clearing pass;
// a full result register stalls the back, the front queue then fills
module bellman_ford_negative_cycle_top import bfnc_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  req_type              req_data,
   output logic                 empty,
   input  logic                 pop,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [VERT_BITS-1:0] csr_wdata
);

   logic [VERT_BITS-1:0] top_ff;
   logic    q_valid, q_take;
   cmd_type q_data;

   // top vertex register
   always_ff @(posedge clock) begin
      if (reset)       top_ff <= 8'd255;
      else if (csr_we) top_ff <= csr_wdata;
   end

   bfnc_front u_front (
      .clock, .reset, .push, .full, .req_data,
      .q_valid, .q_take, .q_data);

   bfnc_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
      .clock, .reset, .top_vertex(top_ff), .q_valid, .q_take, .q_data,
      .empty, .pop, .rsp_data);

endmodule

>>> src/bfnc_checker.sv
// ----------------------------------------------------------------------------
// bfnc_checker
// Port level checks of the detector.
// ----------------------------------------------------------------------------
module bfnc_checker import bfnc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // held result stays stable
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(rsp_data))
      else $error("result changed while waiting");

   // reset leaves the block empty and open
   a_rst: assert property (@(posedge clock) $past(reset) |-> empty && !full)
      else $error("not empty after reset");

   // a waiting result is not withdrawn before it is popped
   a_pop: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty)
      else $error("result withdrawn before pop");

endmodule

bind bellman_ford_negative_cycle_top bfnc_checker u_chk (
   .clock, .reset, .full, .empty, .pop, .rsp_data);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the negative cycle detector. Edge graphs go in
// through the req queue, and each verdict is checked against an in-bench
// Bellman-Ford predictor. A short stimulus table runs first, then random
// graphs under several top vertex settings, idle gaps on both sides, a long
// receiver hold-off and one graph that overflows the edge store.
// ----------------------------------------------------------------------------
module testbench;
   import bfnc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_EDGES   = 20;
   localparam int DOG_LIMIT   = 200000;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 3000;
   localparam int ITEM_TARGET = 1200;

   typedef struct {
      bit            is_cfg;
      logic [7:0]    cfg;
      req_type       e;
      bit            typed;
      rsp_type       exp;
   } plan_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   req_type              req_data = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [VERT_BITS-1:0] csr_wdata = '0;

   // predictor state
   logic [7:0] top_vtx = 8'd255;
   logic [7:0] store_src [0:MAX_EDGES_DEF-1];
   logic [7:0] store_dst [0:MAX_EDGES_DEF-1];
   longint     store_w   [0:MAX_EDGES_DEF-1];
   int         stored = 0;
   bit         dropped_any = 0;
   longint     dist_val [0:MAX_VERTICES_DEF-1];
   bit         seen     [0:MAX_VERTICES_DEF-1];

   rsp_type    verdicts_due[$];
   int         fails = 0;
   int         edges_sent = 0;
   int         verdicts_got = 0;
   int         cycles_found = 0;
   int         overflows_found = 0;
   int         idle_cycles = 0;
   int         hold_left = 0;
   int         pop_gap = 0;
   bit         hold_done = 0;
   plan_row_t  plan[$];

   bellman_ford_negative_cycle_top uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one pass over the stored edges; applies the relaxations, or with apply clear returns 1 if any edge relaxes
   function automatic bit relax_pass(bit apply);
      longint cand;
      for (int k = 0; k < stored; k++) begin
         if (store_src[k] > top_vtx || store_dst[k] > top_vtx) continue;
         if (!seen[store_src[k]]) continue;
         cand = dist_val[store_src[k]] + store_w[k];
         if (!seen[store_dst[k]] || cand < dist_val[store_dst[k]]) begin
            if (!apply) return 1'b1;
            dist_val[store_dst[k]] = cand;
            seen[store_dst[k]] = 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // store one edge; on the final edge run the graph and return the verdict
   function automatic bit predict_verdict(req_type e, output rsp_type v);
      if (stored < MAX_EDGES_DEF) begin
         store_src[stored] = e.src;
         store_dst[stored] = e.dst;
         store_w[stored]   = longint'(e.weight);
         stored++;
      end else begin
         dropped_any = 1'b1;
      end
      v = '0;
      if (!e.last) return 1'b0;
      for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
         dist_val[i] = 0;
         seen[i] = 1'b0;
      end
      seen[top_vtx] = 1'b1;
      for (int p = 0; p < int'(top_vtx); p++) void'(relax_pass(1'b1));
      v.negative_cycle = relax_pass(1'b0);
      v.overflow = dropped_any;
      stored = 0;
      dropped_any = 1'b0;
      return 1'b1;
   endfunction

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // offer one edge until it is taken, then an optional idle gap
   task automatic send_edge(req_type e, bit typed = 0, rsp_type exp = '0);
      rsp_type v;
      push <= 1'b1;
      req_data <= e;
      do @(posedge clock); while (full);
      edges_sent++;
      if (predict_verdict(e, v))
         verdicts_due.insert(verdicts_due.size(), typed ? exp : v);
      case ($urandom_range(0, 19))
         0: begin
            push <= 1'b0;
            wait_cycles($urandom_range(10, 40));
         end
         1, 2, 3, 4, 5: begin
            push <= 1'b0;
            wait_cycles($urandom_range(1, 3));
         end
         default: ;
      endcase
   endtask

   // csr writes only once all verdicts are back and the back end is quiet
   task automatic write_top(logic [7:0] value);
      push <= 1'b0;
      @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      wait_cycles(SETTLE);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      top_vtx = value;
   endtask

   function automatic req_type edge_of(int s, int d, int w, bit lst);
      req_type e;
      e.src = s[7:0];
      e.dst = d[7:0];
      e.weight = w[15:0];
      e.last = lst;
      return e;
   endfunction

   function automatic plan_row_t row(int s, int d, int w, bit lst,
                                     bit typed = 0, bit neg = 0);
      plan_row_t r;
      r.is_cfg = 0;
      r.cfg = '0;
      r.e = edge_of(s, d, w, lst);
      r.typed = typed;
      r.exp.negative_cycle = neg;
      r.exp.overflow = 1'b0;
      return r;
   endfunction

   function automatic plan_row_t cfg_row(int value);
      plan_row_t r;
      r = row(0, 0, 0, 0);
      r.is_cfg = 1;
      r.cfg = value[7:0];
      return r;
   endfunction

   // append one row to the stimulus table
   function automatic void add_row(plan_row_t r);
      plan.insert(plan.size(), r);
   endfunction

   // random graph with well-formed vertices most of the time
   task automatic send_graph(int n);
      int s, d, w;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            s = $urandom_range(0, 255);
            d = $urandom_range(0, 255);
         end else begin
            s = (i == 0 || $urandom_range(0, 3) == 0) ? top_vtx
                                                      : $urandom_range(0, top_vtx);
            d = $urandom_range(0, top_vtx);
         end
         case ($urandom_range(0, 9))
            0: w = $urandom_range(0, 1) ? -32768 : 32767;
            1, 2: w = int'($urandom_range(0, 65535)) - 32768;
            default: w = int'($urandom_range(0, 60)) - 20;
         endcase
         send_edge(edge_of(s, d, w, i == n - 1));
      end
   endtask

   // verdict checking and receiver idling
   always @(posedge clock) begin
      rsp_type want;
      if (pop && !empty) begin
         verdicts_got++;
         if (rsp_data.negative_cycle) cycles_found++;
         if (rsp_data.overflow) overflows_found++;
         if (verdicts_due.size() == 0) begin
            $error("verdict with no transaction pending");
            fails++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_data.negative_cycle !== want.negative_cycle) begin
               $error("negative_cycle: expected %0b actual %0b",
                      want.negative_cycle, rsp_data.negative_cycle);
               fails++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %0b actual %0b",
                      want.overflow, rsp_data.overflow);
               fails++;
            end
         end
      end
      if (verdicts_got == 20 && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop <= 1'b0;
      end else if (reset || pop_gap > 0) begin
         pop_gap <= reset ? 0 : pop_gap - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         case ($urandom_range(0, 19))
            0: pop_gap <= $urandom_range(20, 60);
            1, 2, 3, 4, 5: pop_gap <= $urandom_range(1, 3);
            default: pop_gap <= 0;
         endcase
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= DOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", DOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int graphs;
      int pick;
      // directed table: reset setting first, then small top vertices
      add_row(row(255, 0, -32768, 1, 1, 0));
      add_row(row(255, 0, 32767, 0));
      add_row(row(0, 255, -32768, 1, 1, 1));
      add_row(row(255, 255, -1, 1, 1, 1));
      add_row(row(0, 1, -5, 1, 1, 0));
      add_row(row(170, 85, 21845, 0));
      add_row(row(255, 170, -21846, 1));
      add_row(cfg_row(2));
      add_row(row(3, 0, -100, 0));
      add_row(row(2, 0, 10, 0));
      add_row(row(0, 1, 0, 0));
      add_row(row(1, 0, -10, 1));
      add_row(row(2, 2, 0, 1));
      add_row(row(2, 200, -7, 1));
      add_row(cfg_row(0));
      add_row(row(0, 0, -1, 1));
      add_row(row(0, 0, 5, 1));
      add_row(cfg_row(1));
      add_row(row(1, 0, 4, 0));
      add_row(row(0, 1, -4, 1));
      add_row(row(1, 0, 4, 0));
      add_row(row(0, 1, -5, 1));

      wait_cycles(10);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_top(plan[i].cfg);
         else send_edge(plan[i].e, plan[i].typed, plan[i].exp);
      end

      // overflow: more edges than the store holds, the last six dropped
      write_top(1);
      for (int i = 0; i < MAX_EDGES_DEF + 6; i++)
         send_edge(edge_of($urandom_range(0, 1), $urandom_range(0, 1),
                           int'($urandom_range(0, 40)) - 10,
                           i == MAX_EDGES_DEF + 5));

      // random phases; the first one is long so the hold-off backs up the queue
      write_top(2);
      graphs = 30;
      while (edges_sent < ITEM_TARGET) begin
         repeat (graphs) begin
            pick = $urandom_range(0, 19);
            if (top_vtx == 255 || pick == 0) send_graph($urandom_range(1, 8));
            else if (pick < 3) send_graph($urandom_range(10, 30));
            else send_graph($urandom_range(1, 8));
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) write_top(0);
         else if (pick < 3) write_top(255);
         else if (pick < 5) write_top($urandom_range(16, 254));
         else write_top($urandom_range(1, 15));
         graphs = (top_vtx > 15) ? $urandom_range(1, 3) : $urandom_range(3, 12);
      end

      push <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      wait_cycles(SETTLE);
      $display("%0d edges sent, %0d verdicts checked", edges_sent, verdicts_got);
      $display("%0d negative cycles and %0d store overflows reported",
               cycles_found, overflows_found);
      if (fails == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> bellman_ford_negative_cycle_top.f
src/bfnc_pkg.sv
src/bfnc_ram.sv
src/bfnc_front.sv
src/bfnc_back.sv
src/bellman_ford_negative_cycle_top.sv
src/bfnc_checker.sv
dv/testbench.sv
